// ----- sv/wavpcm_pkg.sv -----
// Shared types, codes and helpers of the RIFF/WAVE PCM16 stream parser.
package wavpcm_pkg;

    // Parse phases
    localparam logic [3:0] PH_RIFF_TAG   = 4'd0;
    localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
    localparam logic [3:0] PH_WAVE_TAG   = 4'd2;
    localparam logic [3:0] PH_CHUNK_ID   = 4'd3;
    localparam logic [3:0] PH_CHUNK_SIZE = 4'd4;
    localparam logic [3:0] PH_FMT        = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_PAD        = 4'd7;
    localparam logic [3:0] PH_DATA       = 4'd8;

    // Final status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TRUNC      = 4'd1;
    localparam logic [3:0] ST_NOT_RIFF   = 4'd2;
    localparam logic [3:0] ST_NOT_WAVE   = 4'd3;
    localparam logic [3:0] ST_FMT_SHORT  = 4'd4;
    localparam logic [3:0] ST_DATA_BAD   = 4'd5;
    localparam logic [3:0] ST_DATA_TRUNC = 4'd6;
    localparam logic [3:0] ST_FORMAT     = 4'd7;
    localparam logic [3:0] ST_MISSING    = 4'd8;

    // Input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Chunk tags, little-endian as collected
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // fmt chunk expectations: format 1 and 1 channel, 16 bits per sample
    localparam logic [31:0] FMT_PCM_MONO = 32'h0001_0001;
    localparam logic [15:0] FMT_BITS     = 16'd16;
    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;

    // fmt field byte positions (after increment)
    localparam logic [4:0] FMT_POS_WORD0 = 5'd4;
    localparam logic [4:0] FMT_POS_RATE  = 5'd8;
    localparam logic [4:0] FMT_POS_END   = 5'd16;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_MAX_DATA = 1'b0;
    localparam logic        REG_RATE     = 1'b1;
    localparam logic [31:0] RST_MAX_DATA = 32'd1920000;
    localparam logic [31:0] RST_RATE     = 32'd16000;

    typedef logic [3:0] phase_t;
    typedef logic [3:0] status_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] sample;
        status_t            status;
        logic               last;
    } out_item_t;

    function automatic out_item_t mk_status(input status_t st);
        out_item_t r;
        r.result_kind = KIND_STATUS;
        r.sample      = '0;
        r.status      = st;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic out_item_t mk_sample(input logic [15:0] s);
        out_item_t r;
        r.result_kind = KIND_SAMPLE;
        r.sample      = $signed(s);
        r.status      = ST_OK;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ----- sv/wavpcm_in_if.sv -----
// Byte input channel of the WAVE parser: valid/ready plus item fields.
interface wavpcm_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] file_byte;

    modport source (output valid, output req_type, output file_byte, input ready);
    modport sink   (input valid, input req_type, input file_byte, output ready);
endinterface

// ----- sv/wavpcm_out_if.sv -----
// Result channel of the WAVE parser: valid/ready plus result fields.
interface wavpcm_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [15:0] sample;
    logic [3:0]         status;
    logic               last;

    modport source (output valid, output result_kind, output sample, output status,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input sample, input status,
                    input last, output ready);
endinterface

// ----- sv/wav_pcm16_stream_parser_core.sv -----
// Top level of the RIFF/WAVE PCM16 stream parser.
//
// Usage:
//   in_ch carries one file byte (req_type 0) or an end-of-file marker
//   (req_type 1) per transfer. out_ch carries samples (result_kind 0, Q1.15)
//   and exactly one final status per file (result_kind 1, last 1).
//   max_data_bytes and expected_rate are written over the APB port at byte
//   addresses 0 and 4; write them only while the block is idle.
// Timing:
//   An accepted item is latched in an input register and parsed when the
//   queue has room; results go to a four-entry result queue and are
//   offered on out_ch from there. One item per cycle is taken while the
//   queue has two free entries, since one byte can produce a sample and the
//   status together; the queue drains one result per cycle while out_ch is ready.
// Reset:
//   rst_n clears the parser to expect a RIFF tag, empties the queue and
//   loads the register defaults (1920000 bytes, 16000 Hz).
// Stalls:
//   When out_ch is held off, the queue fills and in_ch.ready drops; nothing
//   is dropped. Bytes after a status are ignored; an end marker rearms.
module wav_pcm16_stream_parser_core (
    input  logic                            clk,
    input  logic                            rst_n,
    wavpcm_in_if.sink                       in_ch,
    wavpcm_out_if.source                    out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wavpcm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import wavpcm_pkg::*;

    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
    localparam int unsigned CNT_W     = PTR_W + 1;
    localparam logic [CNT_W-1:0] PUSH_ROOM = CNT_W'(OUT_DEPTH - 2);

    // Configuration registers
    logic [31:0] max_data_reg;
    logic [31:0] rate_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_RATE) ? rate_reg : max_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_data_reg <= RST_MAX_DATA;
            rate_reg     <= RST_RATE;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_DATA)
                max_data_reg <= pwdata;
            else
                rate_reg <= pwdata;
        end
    end

    // Input register
    logic       in_vld_reg;
    logic       in_type_reg;
    logic [7:0] in_byte_reg;
    logic       proc_go;
    logic [CNT_W-1:0] cnt_reg;

    assign proc_go     = in_vld_reg && (cnt_reg <= PUSH_ROOM);
    assign in_ch.ready = !in_vld_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ch.ready)
            in_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_type_reg <= in_ch.req_type;
            in_byte_reg <= in_ch.file_byte;
        end
    end

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] field_reg, field_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] left_reg, left_next;
    logic        pad_reg, pad_next;
    logic        seen_reg, seen_next;
    logic        ok_reg, ok_next;
    logic [7:0]  low_reg, low_next;
    logic        sent_reg, sent_next;

    logic [1:0]  push_n;
    out_item_t   res0, res1;

    logic [31:0] col_tag, col_field, left_dec;
    logic [4:0]  pos_inc;
    status_t     eof_st;
    logic        ok_fmt;

    assign col_tag   = {in_byte_reg, tag_reg[31:8]};
    assign col_field = {in_byte_reg, field_reg[31:8]};
    assign left_dec  = left_reg - 32'd1;
    assign pos_inc   = pos_reg + 5'd1;

    // Status for an end marker, by phase
    always_comb
    begin
        case (phase_reg)
            PH_WAVE_TAG: eof_st = ST_NOT_WAVE;
            PH_CHUNK_ID,
            PH_SKIP,
            PH_PAD:      eof_st = ok_reg ? ST_MISSING : ST_FORMAT;
            PH_DATA:     eof_st = ST_DATA_TRUNC;
            default:     eof_st = ST_TRUNC;
        endcase
    end

    // Per-byte parse step
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        field_next = field_reg;
        tag_next   = tag_reg;
        left_next  = left_reg;
        pad_next   = pad_reg;
        seen_next  = seen_reg;
        ok_next    = ok_reg;
        low_next   = low_reg;
        sent_next  = sent_reg;
        push_n     = 2'd0;
        res0       = mk_status(ST_OK);
        res1       = mk_status(ST_OK);
        ok_fmt     = ok_reg;

        if (proc_go)
        begin
            if (in_type_reg == REQ_EOF)
            begin
                if (!sent_reg)
                begin
                    res0   = mk_status(eof_st);
                    push_n = 2'd1;
                end
                // rearm
                phase_next = PH_RIFF_TAG;
                pos_next   = '0;
                field_next = '0;
                tag_next   = '0;
                left_next  = '0;
                pad_next   = 1'b0;
                seen_next  = 1'b0;
                ok_next    = 1'b0;
                low_next   = '0;
                sent_next  = 1'b0;
            end
            else if (!sent_reg)
            begin
                case (phase_reg)
                    PH_RIFF_TAG:
                    begin
                        tag_next = col_tag;
                        pos_next = (pos_inc == 5'd4) ? 5'd0 : pos_inc;
                        if (pos_inc == 5'd4)
                            phase_next = PH_RIFF_SIZE;
                    end
                    PH_RIFF_SIZE:
                    begin
                        field_next = col_field;
                        pos_next   = (pos_inc == 5'd4) ? 5'd0 : pos_inc;
                        if (pos_inc == 5'd4)
                        begin
                            if (tag_reg != TAG_RIFF)
                            begin
                                res0      = mk_status(ST_NOT_RIFF);
                                push_n    = 2'd1;
                                sent_next = 1'b1;
                            end
                            else
                                phase_next = PH_WAVE_TAG;
                        end
                    end
                    PH_WAVE_TAG:
                    begin
                        tag_next = col_tag;
                        pos_next = (pos_inc == 5'd4) ? 5'd0 : pos_inc;
                        if (pos_inc == 5'd4)
                        begin
                            if (col_tag != TAG_WAVE)
                            begin
                                res0      = mk_status(ST_NOT_WAVE);
                                push_n    = 2'd1;
                                sent_next = 1'b1;
                            end
                            else
                                phase_next = PH_CHUNK_ID;
                        end
                    end
                    PH_CHUNK_ID:
                    begin
                        tag_next = col_tag;
                        pos_next = (pos_inc == 5'd4) ? 5'd0 : pos_inc;
                        if (pos_inc == 5'd4)
                            phase_next = PH_CHUNK_SIZE;
                    end
                    PH_CHUNK_SIZE:
                    begin
                        field_next = col_field;
                        pos_next   = (pos_inc == 5'd4) ? 5'd0 : pos_inc;
                        if (pos_inc == 5'd4)
                        begin
                            pad_next = col_field[0];
                            if (tag_reg == TAG_FMT)
                            begin
                                if (col_field < FMT_MIN_LEN)
                                begin
                                    res0      = mk_status(ST_FMT_SHORT);
                                    push_n    = 2'd1;
                                    sent_next = 1'b1;
                                end
                                else
                                begin
                                    left_next  = col_field - FMT_MIN_LEN;
                                    ok_next    = 1'b1;
                                    phase_next = PH_FMT;
                                end
                            end
                            else if (tag_reg == TAG_DATA)
                            begin
                                if (!seen_reg || (col_field == 32'd0) ||
                                    (col_field > max_data_reg) || col_field[0])
                                begin
                                    res0      = mk_status(ST_DATA_BAD);
                                    push_n    = 2'd1;
                                    sent_next = 1'b1;
                                end
                                else
                                begin
                                    left_next  = col_field;
                                    phase_next = PH_DATA;
                                end
                            end
                            else
                            begin
                                left_next = col_field;
                                if (col_field != 32'd0)
                                    phase_next = PH_SKIP;
                                else
                                    phase_next = col_field[0] ? PH_PAD : PH_CHUNK_ID;
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        field_next = col_field;
                        pos_next   = pos_inc;
                        if ((pos_inc == FMT_POS_WORD0) && (col_field != FMT_PCM_MONO))
                            ok_fmt = 1'b0;
                        if ((pos_inc == FMT_POS_RATE) && (col_field != rate_reg))
                            ok_fmt = 1'b0;
                        if (pos_inc >= FMT_POS_END)
                        begin
                            if (col_field[31:16] != FMT_BITS)
                                ok_fmt = 1'b0;
                            pos_next  = 5'd0;
                            seen_next = 1'b1;
                            if (left_reg != 32'd0)
                                phase_next = PH_SKIP;
                            else
                                phase_next = pad_reg ? PH_PAD : PH_CHUNK_ID;
                        end
                        ok_next = ok_fmt;
                    end
                    PH_SKIP:
                    begin
                        left_next = left_dec;
                        if (left_dec == 32'd0)
                            phase_next = pad_reg ? PH_PAD : PH_CHUNK_ID;
                    end
                    PH_PAD:
                    begin
                        phase_next = PH_CHUNK_ID;
                    end
                    PH_DATA:
                    begin
                        left_next = left_dec;
                        if (pos_reg == 5'd0)
                        begin
                            low_next = in_byte_reg;
                            pos_next = 5'd1;
                            if (left_dec == 32'd0)
                            begin
                                res0      = mk_status(ok_reg ? ST_OK : ST_FORMAT);
                                push_n    = 2'd1;
                                sent_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = 5'd0;
                            res0     = mk_sample({in_byte_reg, low_reg});
                            push_n   = 2'd1;
                            if (left_dec == 32'd0)
                            begin
                                res1      = mk_status(ok_reg ? ST_OK : ST_FORMAT);
                                push_n    = 2'd2;
                                sent_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // unused phase code: rearm
                        phase_next = PH_RIFF_TAG;
                        pos_next   = '0;
                        field_next = '0;
                        tag_next   = '0;
                        left_next  = '0;
                        pad_next   = 1'b0;
                        seen_next  = 1'b0;
                        ok_next    = 1'b0;
                        low_next   = '0;
                        sent_next  = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF_TAG;
            pos_reg   <= '0;
            field_reg <= '0;
            tag_reg   <= '0;
            left_reg  <= '0;
            pad_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            low_reg   <= '0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            field_reg <= field_next;
            tag_reg   <= tag_next;
            left_reg  <= left_next;
            pad_reg   <= pad_next;
            seen_reg  <= seen_next;
            ok_reg    <= ok_next;
            low_reg   <= low_next;
            sent_reg  <= sent_next;
        end
    end

    // Result queue: up to two writes, one read per cycle
    out_item_t        out_mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;
    out_item_t        head;

    assign pop      = (cnt_reg != '0) && out_ch.ready;
    assign cnt_next = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            out_mem[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            out_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    assign head               = out_mem[rd_ptr_reg];
    assign out_ch.valid       = (cnt_reg != '0);
    assign out_ch.result_kind = head.result_kind;
    assign out_ch.sample      = head.sample;
    assign out_ch.status      = head.status;
    assign out_ch.last        = head.last;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OUT_DEPTH))
        else $error("result queue over capacity");

    a_status_marks_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && (in_type_reg == REQ_BYTE) && (push_n != 2'd0) &&
         (res0.last || (push_n == 2'd2))) |=> sent_reg)
        else $error("status emitted without closing the file");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_vld_reg && (cnt_reg > PUSH_ROOM)))
        else $error("input stalled without a full queue");

endmodule
